@@ hw/rtl/price_level_order_book_assert.svh @@
// Assertion macros for the order book RTL.
`ifndef PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on the rising clock edge, disabled while reset is asserted.
`define PLOB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("order book check failed");
// Same check, using the block's own clock and reset names.
`define PLOB_ASSERT_LOCAL(lbl, prop) `PLOB_ASSERT(lbl, clk, arst_n, prop)
`else
`define PLOB_ASSERT(lbl, clk, rst_n, prop)
`define PLOB_ASSERT_LOCAL(lbl, prop)
`endif
`endif

@@ hw/rtl/plob_pkg.sv @@
package plob_pkg;
	// Default ladder depth and stored quantity width
	localparam int unsigned LADDER_LEVELS_DEF = 1024;
	localparam int unsigned QTY_BITS_DEF      = 32;
	// Levels covered by one occupancy word
	localparam int unsigned WORD_BITS         = 32;
	localparam int unsigned WORD_SHIFT        = 5;
	// Action codes
	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;
	// Side codes
	localparam logic SIDE_BID   = 1'b0;
	localparam logic SIDE_OFFER = 1'b1;
endpackage

@@ hw/rtl/price_level_order_book.sv @@
// Price-ladder order book for a bid and an offer side. Every accepted request
// gives exactly one result with best bid/offer price, size and valid, the mid in
// half ticks and an off-ladder flag. A clear or an off-ladder update goes from
// S_IDLE straight to S_DONE; an update passes S_RD, then S_SZ when the best
// level is removed and the next one lies in the same 32-level group, or S_WD
// and S_SZ when it lies in another group. The steps follow from the registered
// read of the occupancy and size memories: a level's group word is read,
// modified and written back, and the next best level is found through a
// per-group summary kept in flip-flops. No clearing pass is needed after reset
// or clear: a group whose summary bit is clear reads as empty.
module price_level_order_book #(
	parameter int unsigned LADDER_LEVELS = plob_pkg::LADDER_LEVELS_DEF,
	parameter int unsigned QTY_BITS      = plob_pkg::QTY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] ladder_base_ticks,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic        side,
	input  logic [31:0] price_ticks,
	input  logic [31:0] quantity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        best_bid_valid,
	output logic [31:0] best_bid_price,
	output logic [31:0] best_bid_size,
	output logic        best_offer_valid,
	output logic [31:0] best_offer_price,
	output logic [31:0] best_offer_size,
	output logic [32:0] mid_half_ticks,
	output logic        out_of_range
);
	`include "price_level_order_book_assert.svh"

	localparam int unsigned WB       = plob_pkg::WORD_BITS;
	localparam int unsigned WS       = plob_pkg::WORD_SHIFT;
	localparam int unsigned NGRP_RAW = (LADDER_LEVELS + WB - 1) / WB;
	localparam int unsigned GRP_W    = (NGRP_RAW > 1) ? $clog2(NGRP_RAW) : 1;
	localparam int unsigned NGRP     = 1 << GRP_W;
	localparam int unsigned LVL_W    = GRP_W + WS;

	typedef enum logic [2:0] {S_IDLE, S_RD, S_WD, S_SZ, S_DONE} state_t;

	state_t               state_q;
	logic [31:0]          base_q;
	logic                 side_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [QTY_BITS-1:0]  qty_q;
	logic                 oor_q;
	logic [GRP_W-1:0]     grp_wd_q;
	logic [NGRP-1:0]      sum_q [2];
	logic [LVL_W-1:0]     best_lvl_q [2];
	logic                 best_pres_q [2];
	logic [QTY_BITS-1:0]  best_size_q [2];

	// Input decode
	logic [32:0]         diff;
	logic                in_oor;
	logic [LVL_W-1:0]    in_lvl;
	logic                in_acc;
	assign diff   = {1'b0, price_ticks} - {1'b0, base_q};
	assign in_oor = diff[32] | (diff[31:0] >= 32'(LADDER_LEVELS));
	assign in_lvl = diff[LVL_W-1:0];
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// Memories
	logic                  occ_we;
	logic [GRP_W:0]        occ_raddr;
	logic [WB-1:0]         occ_rdata;
	logic [WB-1:0]         new_word;
	logic                  sz_we;
	logic [LVL_W:0]        sz_raddr;
	logic [QTY_BITS-1:0]   sz_rdata;

	plob_ram #(.WIDTH(WB), .DEPTH(2 * NGRP)) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr ({side_q, lvl_q[LVL_W-1:WS]}),
		.wdata (new_word),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	plob_ram #(.WIDTH(QTY_BITS), .DEPTH(2 * NGRP * WB)) u_size_ram (
		.clk   (clk),
		.we    (sz_we),
		.waddr ({side_q, lvl_q}),
		.wdata (qty_q),
		.raddr (sz_raddr),
		.rdata (sz_rdata)
	);

	// Modify the group word and search for the next best level
	logic [GRP_W-1:0]  grp;
	logic [WS-1:0]     bpos;
	logic [WB-1:0]     cur_word;
	logic [WB-1:0]     one_b;
	logic [WB-1:0]     wcand;
	logic              w_hit;
	logic [WS-1:0]     w_idx;
	logic [NGRP-1:0]   one_g;
	logic [NGRP-1:0]   new_sum;
	logic [NGRP-1:0]   gcand;
	logic              g_hit;
	logic [GRP_W-1:0]  g_idx;
	logic              f_hit;
	logic [WS-1:0]     f_idx;
	logic              qnz;

	assign grp  = lvl_q[LVL_W-1:WS];
	assign bpos = lvl_q[WS-1:0];
	assign qnz  = (qty_q != '0);

	always_comb begin
		cur_word = sum_q[side_q][grp] ? occ_rdata : '0;
		one_b    = WB'(1) << bpos;
		new_word = qnz ? (cur_word | one_b) : (cur_word & ~one_b);
		one_g    = NGRP'(1) << grp;
		new_sum  = (new_word != '0) ? (sum_q[side_q] | one_g) : (sum_q[side_q] & ~one_g);
		if (side_q == plob_pkg::SIDE_BID) begin
			wcand = new_word & (one_b - WB'(1));
			gcand = new_sum & (one_g - NGRP'(1));
		end else begin
			wcand = new_word & ~((one_b - WB'(1)) | one_b);
			gcand = new_sum & ~((one_g - NGRP'(1)) | one_g);
		end
		w_hit = 1'b0;
		w_idx = '0;
		g_hit = 1'b0;
		g_idx = '0;
		f_hit = 1'b0;
		f_idx = '0;
		if (side_q == plob_pkg::SIDE_BID) begin
			for (int i = 0; i < WB; i++) begin
				if (wcand[i]) begin
					w_hit = 1'b1;
					w_idx = WS'(i);
				end
				if (occ_rdata[i]) begin
					f_hit = 1'b1;
					f_idx = WS'(i);
				end
			end
			for (int i = 0; i < NGRP; i++) begin
				if (gcand[i]) begin
					g_hit = 1'b1;
					g_idx = GRP_W'(i);
				end
			end
		end else begin
			for (int i = WB - 1; i >= 0; i--) begin
				if (wcand[i]) begin
					w_hit = 1'b1;
					w_idx = WS'(i);
				end
				if (occ_rdata[i]) begin
					f_hit = 1'b1;
					f_idx = WS'(i);
				end
			end
			for (int i = NGRP - 1; i >= 0; i--) begin
				if (gcand[i]) begin
					g_hit = 1'b1;
					g_idx = GRP_W'(i);
				end
			end
		end
	end

	// Read addresses and write enables
	logic need_search;
	assign need_search = ~qnz & best_pres_q[side_q] & (best_lvl_q[side_q] == lvl_q);
	assign occ_we = (state_q == S_RD);
	assign sz_we  = (state_q == S_RD);

	always_comb begin
		unique case (state_q)
			S_IDLE:  occ_raddr = {side, in_lvl[LVL_W-1:WS]};
			default: occ_raddr = {side_q, g_idx};
		endcase
		unique case (state_q)
			S_WD:    sz_raddr = {side_q, grp_wd_q, f_idx};
			default: sz_raddr = {side_q, grp, w_idx};
		endcase
	end

	// Result values
	logic [31:0] bp;
	logic [31:0] op;
	assign bp = best_pres_q[0] ? (base_q + 32'(best_lvl_q[0])) : '0;
	assign op = best_pres_q[1] ? (base_q + 32'(best_lvl_q[1])) : '0;

	// Sequence one request through the memories and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			base_q           <= '0;
			out_valid        <= 1'b0;
			side_q           <= plob_pkg::SIDE_BID;
			lvl_q            <= '0;
			qty_q            <= '0;
			grp_wd_q         <= '0;
			sum_q[0]         <= '0;
			sum_q[1]         <= '0;
			best_lvl_q[0]    <= '0;
			best_lvl_q[1]    <= '0;
			best_pres_q[0]   <= 1'b0;
			best_pres_q[1]   <= 1'b0;
			best_size_q[0]   <= '0;
			best_size_q[1]   <= '0;
			oor_q            <= 1'b0;
			best_bid_valid   <= 1'b0;
			best_bid_price   <= '0;
			best_bid_size    <= '0;
			best_offer_valid <= 1'b0;
			best_offer_price <= '0;
			best_offer_size  <= '0;
			mid_half_ticks   <= '0;
			out_of_range     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				base_q <= ladder_base_ticks;
			end
			// Raise valid when a result loads, drop it once taken
			if (state_q == S_DONE && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						side_q <= side;
						lvl_q  <= in_lvl;
						qty_q  <= QTY_BITS'(quantity);
						oor_q  <= 1'b0;
						if (action == plob_pkg::ACT_CLEAR) begin
							sum_q[0]       <= '0;
							sum_q[1]       <= '0;
							best_lvl_q[0]  <= '0;
							best_lvl_q[1]  <= '0;
							best_pres_q[0] <= 1'b0;
							best_pres_q[1] <= 1'b0;
							state_q        <= S_DONE;
						end else if (in_oor) begin
							oor_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					sum_q[side_q] <= new_sum;
					state_q       <= S_DONE;
					if (qnz) begin
						if (!best_pres_q[side_q] || best_lvl_q[side_q] == lvl_q ||
							((side_q == plob_pkg::SIDE_BID) ? (lvl_q > best_lvl_q[side_q])
							: (lvl_q < best_lvl_q[side_q]))) begin
							best_lvl_q[side_q]  <= lvl_q;
							best_pres_q[side_q] <= 1'b1;
							best_size_q[side_q] <= qty_q;
						end
					end else if (need_search) begin
						if (w_hit) begin
							best_lvl_q[side_q] <= {grp, w_idx};
							state_q            <= S_SZ;
						end else if (g_hit) begin
							grp_wd_q <= g_idx;
							state_q  <= S_WD;
						end else begin
							best_lvl_q[side_q]  <= '0;
							best_pres_q[side_q] <= 1'b0;
						end
					end
				end
				S_WD: begin
					best_lvl_q[side_q] <= {grp_wd_q, f_idx};
					state_q            <= S_SZ;
				end
				S_SZ: begin
					best_size_q[side_q] <= sz_rdata;
					state_q             <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						best_bid_valid   <= best_pres_q[0];
						best_bid_price   <= bp;
						best_bid_size    <= best_pres_q[0] ? 32'(best_size_q[0]) : '0;
						best_offer_valid <= best_pres_q[1];
						best_offer_price <= op;
						best_offer_size  <= best_pres_q[1] ? 32'(best_size_q[1]) : '0;
						mid_half_ticks   <= (best_pres_q[0] && best_pres_q[1]) ?
							({1'b0, bp} + {1'b0, op}) : '0;
						out_of_range     <= oor_q;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Book state after a clear request
	logic clr_acc;
	logic book_empty;
	assign clr_acc    = in_acc && (action == plob_pkg::ACT_CLEAR);
	assign book_empty = (sum_q[0] == '0) && (sum_q[1] == '0) &&
		!best_pres_q[0] && !best_pres_q[1];

	`PLOB_ASSERT_LOCAL(a_clear_empties, clr_acc |=> book_empty)
	`PLOB_ASSERT_LOCAL(a_bid_empty_lvl0, !best_pres_q[0] |-> best_lvl_q[0] == '0)
	`PLOB_ASSERT_LOCAL(a_offer_empty_lvl0, !best_pres_q[1] |-> best_lvl_q[1] == '0)
	`PLOB_ASSERT_LOCAL(a_one_write, (state_q == S_RD) |=> (state_q != S_RD))
endmodule

@@ hw/rtl/plob_ram.sv @@
module plob_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	localparam int unsigned LEVELS = plob_pkg::LADDER_LEVELS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic UPDATE = plob_pkg::ACT_UPDATE;
	localparam logic CLEAR  = plob_pkg::ACT_CLEAR;
	localparam logic BID    = plob_pkg::SIDE_BID;
	localparam logic OFFER  = plob_pkg::SIDE_OFFER;

	typedef struct packed {
		logic        act;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
	} book_request_t;

	typedef struct packed {
		logic        bid_valid;
		logic [31:0] bid_price;
		logic [31:0] bid_size;
		logic        offer_valid;
		logic [31:0] offer_price;
		logic [31:0] offer_size;
		logic [32:0] mid;
		logic        off_ladder;
	} top_of_book_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] ladder_base_ticks;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic        side;
	logic [31:0] price_ticks;
	logic [31:0] quantity;
	logic        out_valid;
	logic        out_stall;
	logic        best_bid_valid;
	logic [31:0] best_bid_price;
	logic [31:0] best_bid_size;
	logic        best_offer_valid;
	logic [31:0] best_offer_price;
	logic [31:0] best_offer_size;
	logic [32:0] mid_half_ticks;
	logic        out_of_range;

	price_level_order_book u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.ladder_base_ticks(ladder_base_ticks),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.side             (side),
		.price_ticks      (price_ticks),
		.quantity         (quantity),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.best_bid_valid   (best_bid_valid),
		.best_bid_price   (best_bid_price),
		.best_bid_size    (best_bid_size),
		.best_offer_valid (best_offer_valid),
		.best_offer_price (best_offer_price),
		.best_offer_size  (best_offer_size),
		.mid_half_ticks   (mid_half_ticks),
		.out_of_range     (out_of_range)
	);

	// Shadow book
	logic [31:0] bid_qty [LEVELS];
	logic [31:0] offer_qty [LEVELS];
	logic [31:0] base_ticks;
	int unsigned top_bid_lvl, top_offer_lvl;
	bit          bid_live, offer_live;

	book_request_t pending_requests [$];
	top_of_book_t  expected_tops [$];

	int unsigned sender_idle_pct, receiver_stall_pct;
	int unsigned errors, requests_sent, tops_checked, clears_seen, off_ladder_seen;
	int unsigned cycles;

	always #4 clk = ~clk;

	function automatic void wipe_book();
		for (int i = 0; i < LEVELS; i++) begin
			bid_qty[i] = '0;
			offer_qty[i] = '0;
		end
		top_bid_lvl = 0;
		top_offer_lvl = 0;
		bid_live = 0;
		offer_live = 0;
	endfunction

	// Append one request to the pending queue
	function automatic void add_request(book_request_t r);
		pending_requests.insert(pending_requests.size(), r);
	endfunction

	// Apply one request to the shadow book and return the resulting top of book
	function automatic top_of_book_t apply_book_request(book_request_t r);
		top_of_book_t t;
		logic [32:0] span;
		int unsigned lvl;
		t = '0;
		span = {1'b0, r.price} - {1'b0, base_ticks};
		if (r.act == CLEAR) begin
			wipe_book();
		end else if (r.price < base_ticks || span >= LEVELS) begin
			t.off_ladder = 1'b1;
		end else begin
			lvl = span[31:0];
			if (r.side == BID) begin
				bid_qty[lvl] = r.qty;
				if (r.qty != 0) begin
					if (!bid_live || lvl > top_bid_lvl) begin
						top_bid_lvl = lvl;
						bid_live = 1;
					end
				end else if (bid_live && lvl == top_bid_lvl) begin
					// search down for the next bid
					bid_live = 0;
					top_bid_lvl = 0;
					for (int i = int'(lvl) - 1; i >= 0; i--)
						if (bid_qty[i] != 0) begin
							top_bid_lvl = i;
							bid_live = 1;
							break;
						end
				end
			end else begin
				offer_qty[lvl] = r.qty;
				if (r.qty != 0) begin
					if (!offer_live || lvl < top_offer_lvl) begin
						top_offer_lvl = lvl;
						offer_live = 1;
					end
				end else if (offer_live && lvl == top_offer_lvl) begin
					// search up for the next offer
					offer_live = 0;
					top_offer_lvl = 0;
					for (int i = lvl + 1; i < LEVELS; i++)
						if (offer_qty[i] != 0) begin
							top_offer_lvl = i;
							offer_live = 1;
							break;
						end
				end
			end
		end
		if (bid_live) begin
			t.bid_valid = 1'b1;
			t.bid_price = base_ticks + top_bid_lvl;
			t.bid_size = bid_qty[top_bid_lvl];
		end
		if (offer_live) begin
			t.offer_valid = 1'b1;
			t.offer_price = base_ticks + top_offer_lvl;
			t.offer_size = offer_qty[top_offer_lvl];
		end
		if (bid_live && offer_live)
			t.mid = {1'b0, t.bid_price} + {1'b0, t.offer_price};
		return t;
	endfunction

	// Drive requests from the pending queue
	always @(posedge clk or negedge arst_n) begin
		book_request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= UPDATE;
			side <= BID;
			price_ticks <= '0;
			quantity <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				r = '{action, side, price_ticks, quantity};
				expected_tops.insert(expected_tops.size(), apply_book_request(r));
				requests_sent++;
				if (r.act == CLEAR)
					clears_seen++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					action <= r.act;
					side <= r.side;
					price_ticks <= r.price;
					quantity <= r.qty;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side and check each accepted result
	always @(posedge clk or negedge arst_n) begin
		top_of_book_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_tops.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = expected_tops.pop_front();
					tops_checked++;
					if (out_of_range)
						off_ladder_seen++;
					if (best_bid_valid !== e.bid_valid) begin
						$error("best_bid_valid exp %0h got %0h", e.bid_valid, best_bid_valid);
						errors++;
					end
					if (best_bid_price !== e.bid_price) begin
						$error("best_bid_price exp %0h got %0h", e.bid_price, best_bid_price);
						errors++;
					end
					if (best_bid_size !== e.bid_size) begin
						$error("best_bid_size exp %0h got %0h", e.bid_size, best_bid_size);
						errors++;
					end
					if (best_offer_valid !== e.offer_valid) begin
						$error("best_offer_valid exp %0h got %0h", e.offer_valid,
							best_offer_valid);
						errors++;
					end
					if (best_offer_price !== e.offer_price) begin
						$error("best_offer_price exp %0h got %0h", e.offer_price,
							best_offer_price);
						errors++;
					end
					if (best_offer_size !== e.offer_size) begin
						$error("best_offer_size exp %0h got %0h", e.offer_size,
							best_offer_size);
						errors++;
					end
					if (mid_half_ticks !== e.mid) begin
						$error("mid_half_ticks exp %0h got %0h", e.mid, mid_half_ticks);
						errors++;
					end
					if (out_of_range !== e.off_ladder) begin
						$error("out_of_range exp %0h got %0h", e.off_ladder, out_of_range);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic book_request_t make_request(logic act, logic sd, int unsigned lvl,
		logic [31:0] q);
		book_request_t r;
		r.act = act;
		r.side = sd;
		r.price = base_ticks + lvl;
		r.qty = q;
		return r;
	endfunction

	// Random request, mostly on the ladder and clustered so best levels get removed
	function automatic book_request_t random_request();
		book_request_t r;
		logic [32:0] room;
		int unsigned top_lvl, roll;
		room = 33'h1_0000_0000 - {1'b0, base_ticks};
		top_lvl = (room < LEVELS) ? 32'(room - 33'd1) : LEVELS - 1;
		roll = $urandom_range(99);
		r.side = $urandom_range(1);
		r.act = UPDATE;
		r.qty = ($urandom_range(99) < 35) ? 32'd0 :
			($urandom_range(1) ? $urandom : $urandom_range(255, 1));
		if (roll < 3) begin
			r.act = CLEAR;
			r.price = $urandom;
		end else if (roll < 11) begin
			r.price = $urandom;
		end else begin
			r.price = base_ticks + (($urandom_range(1) == 0) ?
				$urandom_range(top_lvl < 31 ? top_lvl : 31) : $urandom_range(top_lvl));
		end
		return r;
	endfunction

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_tops.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_base(logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		ladder_base_ticks <= v;
		do @(posedge clk);
		while (!cfg_ready);
		base_ticks = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random(int unsigned n);
		repeat (n) add_request(random_request());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		ladder_base_ticks = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		base_ticks = '0;
		wipe_book();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ladder ends, searches, emptied sides, off-ladder and clear
		add_request(make_request(UPDATE, BID, 0, 32'hFFFF_FFFF));
		add_request(make_request(UPDATE, BID, LEVELS - 1, 32'd7));
		add_request(make_request(UPDATE, BID, LEVELS, 32'd9));
		add_request(make_request(UPDATE, OFFER, 5, 32'd3));
		add_request(make_request(UPDATE, OFFER, 40, 32'd11));
		add_request(make_request(UPDATE, OFFER, LEVELS - 1, 32'd1));
		add_request(make_request(UPDATE, OFFER, 40, 32'd0));
		add_request(make_request(UPDATE, OFFER, 5, 32'd0));
		add_request(make_request(UPDATE, OFFER, LEVELS - 1, 32'd0));
		add_request(make_request(UPDATE, BID, 3, 32'd0));
		add_request(make_request(UPDATE, BID, LEVELS - 1, 32'd0));
		add_request(make_request(UPDATE, BID, 0, 32'd0));
		add_request(make_request(UPDATE, OFFER, 0, 32'd0));
		add_request('{UPDATE, BID, 32'hFFFF_FFFF, 32'hA5A5_5A5A});
		add_request(make_request(UPDATE, BID, 100, 32'd2));
		add_request(make_request(UPDATE, OFFER, 200, 32'h8000_0000));
		add_request('{CLEAR, OFFER, 32'h5555_5555, 32'hFFFF_FFFF});
		add_request(make_request(UPDATE, OFFER, 1, 32'd4));
		queue_random(250);
		wait_drained();

		// Top of the price range, sender idling
		write_base(32'hFFFF_FFFF);
		sender_idle_pct = 60;
		queue_random(120);
		wait_drained();
		write_base(32'hFFFF_FC00);
		queue_random(140);
		wait_drained();

		// Receiver stalling
		sender_idle_pct = 0;
		receiver_stall_pct = 60;
		write_base($urandom);
		queue_random(260);
		wait_drained();

		// Both idling, with one full pause mid-phase
		sender_idle_pct = 24;
		receiver_stall_pct = 24;
		write_base(32'd1000);
		queue_random(130);
		wait_drained();
		queue_random(140);
		wait_drained();

		$display("Covered %0d requests (%0d clears, %0d off-ladder) and %0d checked results",
			requests_sent, clears_seen, off_ladder_seen, tops_checked);
		$display("across five ladder bases and four idle/stall mixes");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/plob_pkg.sv
hw/rtl/plob_ram.sv
hw/rtl/price_level_order_book.sv
tb/sv/tb.sv
